// ===== hw/rtl/sle_pkg.sv =====
package sle_pkg;

    localparam int LINE_MAX   = 63;
    localparam int WRAP_COUNT = 1024;
    localparam int TABLE_LEN  = 90;
    localparam int CNT_W      = 11;
    localparam int IDX_W      = $clog2(LINE_MAX + 1);
    localparam int CODE_W     = 8;
    localparam int CHAR_W     = 8;
    localparam int KIND_W     = 2;
    localparam int MAP_W      = $clog2(TABLE_LEN);

    localparam logic [CNT_W-1:0]  WRAP_CNT  = CNT_W'(WRAP_COUNT);
    localparam logic [CNT_W-1:0]  LINE_CNT  = CNT_W'(LINE_MAX);
    localparam logic [IDX_W-1:0]  LINE_IDX  = IDX_W'(LINE_MAX);

    localparam logic [CODE_W-2:0] CAPS_CODE = 7'h3a;
    localparam logic [CHAR_W-1:0] LED_CMD   = 8'hed;
    localparam logic [CHAR_W-1:0] CHAR_BS   = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_LF   = 8'h0a;

    typedef enum logic [KIND_W-1:0] {
        KIND_ECHO = 2'd0,
        KIND_LINE = 2'd1,
        KIND_CMD  = 2'd2
    } t_kind;

    typedef struct packed {
        logic load;
        logic emit_echo;
        logic emit_led;
        logic emit_caps;
        logic emit_line;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic is_release;
        logic is_caps_rel;
        logic is_enter;
        logic len_zero;
        logic line_last;
    } t_status;

    localparam logic [CHAR_W-1:0] PLAIN_MAP [0:TABLE_LEN-1] = '{
        0, 27, 49, 50, 51, 52, 53, 54, 55, 56, 57, 48, 45, 61, 8,
        9, 113, 119, 101, 114, 116, 121, 117, 105, 111, 112, 91, 93, 10, 0,
        97, 115, 100, 102, 103, 104, 106, 107, 108, 59, 39, 96, 0, 92, 122,
        120, 99, 118, 98, 110, 109, 44, 46, 47, 0, 42, 0, 32, 0, 0, 0, 0, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 0, 254, 0, 45, 252, 0, 253, 43, 0, 255, 0, 0, 0,
        0, 0, 0, 0, 0, 0
    };

    localparam logic [CHAR_W-1:0] SHIFT_MAP [0:TABLE_LEN-1] = '{
        0, 27, 33, 64, 35, 36, 37, 94, 38, 42, 40, 41, 95, 43, 8,
        9, 81, 87, 69, 82, 84, 89, 85, 73, 79, 80, 123, 125, 10, 0,
        65, 83, 68, 70, 71, 72, 74, 75, 76, 58, 34, 126, 0, 124, 90,
        88, 67, 86, 66, 78, 77, 60, 62, 63, 0, 42, 0, 32, 0, 0, 0, 0, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 0, 254, 0, 45, 252, 0, 253, 43, 0, 255, 0, 0, 0,
        0, 0, 0, 0, 0, 0
    };

endpackage

// ===== hw/rtl/sle_ram.sv =====
module sle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/sle_ctrl.sv =====
module sle_ctrl
    import sle_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_CAPS,
        S_LINE
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_status.is_release) begin
                    if (!i_status.is_caps_rel) begin
                        n_state = S_IDLE;
                    end else if (i_status.out_free) begin
                        cmd.emit_led = 1'b1;
                        n_state      = S_CAPS;
                    end
                end else if (i_status.out_free) begin
                    cmd.emit_echo = 1'b1;
                    if (i_status.is_enter && !i_status.len_zero) begin
                        n_state = S_LINE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_CAPS: begin
                if (i_status.out_free) begin
                    cmd.emit_caps = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_LINE: begin
                if (i_status.out_free) begin
                    cmd.emit_line = 1'b1;
                    if (i_status.line_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

endmodule

// ===== hw/rtl/sle_dp.sv =====
module sle_dp
    import sle_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    input  logic [CODE_W-1:0] i_code,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [KIND_W-1:0] o_kind,
    output logic [CHAR_W-1:0] o_value,
    output logic              o_last
);

    logic [CODE_W-1:0] r_code;
    logic [CNT_W-1:0]  r_count;
    logic              r_caps;
    logic [IDX_W-1:0]  r_len;
    logic [IDX_W-1:0]  r_idx;
    logic              r_valid;
    t_kind             r_kind;
    logic [CHAR_W-1:0] r_value;
    logic              r_last;

    logic [CHAR_W-1:0] ch;
    logic              in_table;
    logic [MAP_W-1:0]  map_idx;
    logic              is_bs;
    logic              is_enter;
    logic              len_zero;
    logic              line_last;
    logic              store_we;
    logic [IDX_W-1:0]  rd_addr;
    logic [CHAR_W-1:0] rd_data;
    logic [IDX_W-1:0]  enter_len;
    logic              out_free;

    assign in_table  = (r_code < CODE_W'(TABLE_LEN));
    assign map_idx   = r_code[MAP_W-1:0];
    assign ch        = !in_table ? '0 : (r_caps ? SHIFT_MAP[map_idx] : PLAIN_MAP[map_idx]);
    assign is_bs     = (ch == CHAR_BS);
    assign is_enter  = (ch == CHAR_LF);
    assign len_zero  = (r_count == '0);
    assign enter_len = (r_count < LINE_CNT) ? r_count[IDX_W-1:0] : LINE_IDX;
    assign line_last = (r_idx == (r_len - IDX_W'(1)));
    assign out_free  = !r_valid || i_out_ready;
    assign store_we  = i_cmd.emit_echo && !is_enter && !is_bs && (r_count < LINE_CNT);
    assign rd_addr   = (i_cmd.emit_line && !line_last) ? (r_idx + IDX_W'(1)) : r_idx;

    sle_ram #(
        .WIDTH(CHAR_W),
        .DEPTH(LINE_MAX)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (store_we),
        .i_waddr(r_count[IDX_W-1:0]),
        .i_wdata(ch),
        .i_raddr(rd_addr),
        .o_rdata(rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_caps  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (r_count >= WRAP_CNT) begin
                    r_count <= '0;
                end
            end else if (i_cmd.emit_echo) begin
                if (is_enter) begin
                    r_count <= '0;
                end else if (is_bs) begin
                    if (!len_zero) begin
                        r_count <= r_count - CNT_W'(1);
                    end
                end else begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (i_cmd.emit_led) begin
                r_caps <= ~r_caps;
            end
            if (i_cmd.emit_echo || i_cmd.emit_led || i_cmd.emit_caps || i_cmd.emit_line) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_code <= i_code;
            r_idx  <= '0;
        end
        if (i_cmd.emit_echo) begin
            r_len   <= enter_len;
            r_kind  <= KIND_ECHO;
            r_value <= ch;
            r_last  <= !(is_enter && !len_zero);
        end
        if (i_cmd.emit_led) begin
            r_kind  <= KIND_CMD;
            r_value <= LED_CMD;
            r_last  <= 1'b0;
        end
        if (i_cmd.emit_caps) begin
            r_kind  <= KIND_CMD;
            r_value <= {5'd0, r_caps, 2'd0};
            r_last  <= 1'b1;
        end
        if (i_cmd.emit_line) begin
            r_kind  <= KIND_LINE;
            r_value <= rd_data;
            r_last  <= line_last;
            r_idx   <= r_idx + IDX_W'(1);
        end
    end

    assign o_status.out_free    = out_free;
    assign o_status.is_release  = r_code[CODE_W-1];
    assign o_status.is_caps_rel = (r_code[CODE_W-2:0] == CAPS_CODE);
    assign o_status.is_enter    = is_enter;
    assign o_status.len_zero    = len_zero;
    assign o_status.line_last   = line_last;

    assign o_out_valid = r_valid;
    assign o_kind      = r_kind;
    assign o_value     = r_value;
    assign o_last      = r_last;

endmodule

// ===== hw/rtl/scancode_line_editor_unit.sv =====
// Channel   Direction  Handshake           Payload
// s_*       in         s_tvalid/s_tready   s_tdata[7:0] = scancode
// m_*       out        m_tvalid/m_tready   m_tdata[7:0] = value, m_tuser[1:0] = kind,
//                                          m_tlast = last
// One item at a time: accept, decode, then one result per cycle unless the output stalls.
// A caps release gives two results. Enter with stored characters also sends the line; the
// line store has a registered read port that is read one address ahead of the output.
// Synchronous active-low reset clears the count, the caps flag and the output valid.
// Output stalls hold the sequencer; the next item is accepted while the last
// result still waits in the output register.
module scancode_line_editor_unit
    import sle_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CODE_W-1:0] s_tdata,   // [7:0] scancode
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CHAR_W-1:0] m_tdata,   // [7:0] value
    output logic [KIND_W-1:0] m_tuser,   // [1:0] kind
    output logic              m_tlast
);

    t_cmd    cmd;
    t_status status;

    sle_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_tvalid),
        .o_in_ready(s_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    sle_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_code     (s_tdata),
        .o_out_valid(m_tvalid),
        .i_out_ready(m_tready),
        .o_kind     (m_tuser),
        .o_value    (m_tdata),
        .o_last     (m_tlast)
    );

endmodule

// ===== sim/tb_scancode_line_editor_unit.sv =====
`timescale 1ns / 1ps

module tb_scancode_line_editor_unit;
    import sle_pkg::*;

    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          SETTLE_WAIT  = 80;
    localparam int          ITEM_TARGET  = 220;
    localparam int          KEY_TBL_LEN  = 90;
    localparam int          STORE_LEN    = 63;
    localparam int          COUNT_WRAP   = 1024;
    localparam logic [7:0]  KEY_ENTER    = 8'h1c;
    localparam logic [7:0]  KEY_BKSP     = 8'h0e;
    localparam logic [7:0]  KEY_CAPS_REL = 8'hba;
    localparam logic [7:0]  REL_FLAG     = 8'h80;
    localparam logic [7:0]  LED_BYTE     = 8'hed;
    localparam logic [7:0]  CH_NEWLINE   = 8'h0a;
    localparam logic [7:0]  CH_BKSP      = 8'h08;

    localparam logic [7:0] DIRECTED [23] = '{
        8'h1c, 8'h0e, 8'h00, 8'h7f, 8'h59, 8'h5a, 8'h48, 8'h50, 8'h10, 8'h02,
        8'h0e, 8'h1c, 8'h80, 8'hff, 8'h9c, 8'hba, 8'h10, 8'h35, 8'h3a, 8'h0d,
        8'h1c, 8'hba, 8'h8e
    };

    typedef struct packed {
        t_kind             kind;
        logic [CHAR_W-1:0] value;
        logic              last;
    } t_key_result;

    class line_editor_sb;
        logic [7:0]   plain_tbl [KEY_TBL_LEN];
        logic [7:0]   shift_tbl [KEY_TBL_LEN];
        logic [10:0]  char_count;
        logic         caps_on;
        logic [7:0]   line_buf [STORE_LEN];
        t_key_result  expected [$];
        int           errors;

        function new();
            plain_tbl = '{
                0, 27, 49, 50, 51, 52, 53, 54, 55, 56, 57, 48, 45, 61, 8,
                9, 113, 119, 101, 114, 116, 121, 117, 105, 111, 112, 91, 93, 10, 0,
                97, 115, 100, 102, 103, 104, 106, 107, 108, 59, 39, 96, 0, 92, 122,
                120, 99, 118, 98, 110, 109, 44, 46, 47, 0, 42, 0, 32, 0, 0, 0, 0, 0, 0,
                0, 0, 0, 0, 0, 0, 0, 0, 254, 0, 45, 252, 0, 253, 43, 0, 255, 0, 0, 0,
                0, 0, 0, 0, 0, 0
            };
            shift_tbl = '{
                0, 27, 33, 64, 35, 36, 37, 94, 38, 42, 40, 41, 95, 43, 8,
                9, 81, 87, 69, 82, 84, 89, 85, 73, 79, 80, 123, 125, 10, 0,
                65, 83, 68, 70, 71, 72, 74, 75, 76, 58, 34, 126, 0, 124, 90,
                88, 67, 86, 66, 78, 77, 60, 62, 63, 0, 42, 0, 32, 0, 0, 0, 0, 0, 0,
                0, 0, 0, 0, 0, 0, 0, 0, 254, 0, 45, 252, 0, 253, 43, 0, 255, 0, 0, 0,
                0, 0, 0, 0, 0, 0
            };
            char_count = '0;
            caps_on    = 1'b0;
            foreach (line_buf[i]) line_buf[i] = '0;
            errors     = 0;
        endfunction

        function void add_result(t_kind kind, logic [7:0] value);
            t_key_result r;
            r.kind  = kind;
            r.value = value;
            r.last  = 1'b0;
            expected.push_back(r);
        endfunction

        function void note_scancode(logic [7:0] code);
            logic [7:0] ch;
            int         n_before;
            int         len;
            n_before = expected.size();
            if (char_count >= COUNT_WRAP)
                char_count = '0;
            if (code & REL_FLAG) begin
                if (code == KEY_CAPS_REL) begin
                    caps_on = ~caps_on;
                    add_result(KIND_CMD, LED_BYTE);
                    add_result(KIND_CMD, {5'b0, caps_on, 2'b0});
                end
            end else begin
                ch = 8'h00;
                if (code < KEY_TBL_LEN)
                    ch = caps_on ? shift_tbl[code[6:0]] : plain_tbl[code[6:0]];
                add_result(KIND_ECHO, ch);
                if (ch == CH_NEWLINE) begin
                    len = (char_count < STORE_LEN) ? int'(char_count) : STORE_LEN;
                    for (int i = 0; i < len; i++)
                        add_result(KIND_LINE, line_buf[i]);
                    char_count = '0;
                end else if (ch == CH_BKSP) begin
                    if (char_count != 0)
                        char_count = char_count - 1'b1;
                end else begin
                    if (char_count < STORE_LEN)
                        line_buf[char_count] = ch;
                    char_count = char_count + 1'b1;
                end
            end
            if (expected.size() > n_before)
                expected[expected.size()-1].last = 1'b1;
        endfunction

        function void check_result(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] value,
                                   logic last);
            t_key_result want;
            if (expected.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected item kind=%0d value=%02h last=%0b",
                             $realtime, kind, value, last);
                return;
            end
            want = expected.pop_front();
            if (kind !== want.kind || value !== want.value || last !== want.last) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: mismatch exp %0d/%02h/%0b got %0d/%02h/%0b",
                             $realtime, want.kind, want.value, want.last,
                             kind, value, last);
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [CODE_W-1:0] s_tdata;    // [7:0] scancode
    logic              m_tvalid;
    logic              m_tready;
    logic [CHAR_W-1:0] m_tdata;    // [7:0] value
    logic [KIND_W-1:0] m_tuser;    // [1:0] kind
    logic              m_tlast;

    line_editor_sb sb;
    int            cycle_count;
    bit            idle_on;
    int            hold_cycles;

    scancode_line_editor_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    initial cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata, m_tlast);
            if (s_tvalid && s_tready)
                sb.note_scancode(s_tdata);
        end
    end

    // receiver: random stalls, and a long hold-off when requested
    initial begin
        int stall;
        int held;
        m_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                held        = hold_cycles;
                hold_cycles = 0;
                m_tready <= 1'b0;
                repeat (held) @(posedge i_clk);
            end
            stall = idle_on ? $urandom_range(0, 3) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
        end
    end

    task automatic send_scancode(input logic [7:0] code);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        do @(posedge i_clk); while (!s_tready);
    endtask

    function automatic logic [7:0] pick_char();
        logic [7:0] code;
        do code = 8'($urandom_range(0, 127));
        while (code == KEY_ENTER || code == KEY_BKSP);
        return code;
    endfunction

    initial begin
        int         n_items;
        int         line_no;
        int         len;
        int         sel;
        logic [7:0] code;

        sb          = new();
        idle_on     = 1'b1;
        hold_cycles = 0;
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[i])
            send_scancode(DIRECTED[i]);

        n_items = $size(DIRECTED);
        line_no = 0;
        while (n_items < ITEM_TARGET) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if (line_no == 1) begin
                len = $urandom_range(64, 70);
            end else if (line_no == 2) begin
                hold_cycles = 300;
                len         = 40;
            end else if (line_no > 2 && $urandom_range(0, 7) == 0) begin
                len = $urandom_range(60, 70);
            end else begin
                len = $urandom_range(0, 12);
            end
            if (line_no > 2 && len > ITEM_TARGET - n_items - 1)
                len = ITEM_TARGET - n_items - 1;
            for (int i = 0; i < len; i++) begin
                sel = (line_no == 1) ? 0 : $urandom_range(0, 19);
                if (sel < 14)
                    code = pick_char();
                else if (sel < 16)
                    code = KEY_BKSP;
                else if (sel == 16)
                    code = KEY_CAPS_REL;
                else if (sel == 17)
                    code = REL_FLAG | 8'($urandom_range(0, 127));
                else
                    code = 8'($urandom_range(0, 255));
                send_scancode(code);
                n_items++;
            end
            send_scancode(KEY_ENTER);
            n_items++;
            line_no++;
        end
        s_tvalid <= 1'b0;

        @(posedge i_clk);
        while (sb.expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);

        if (sb.errors == 0 && sb.expected.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== scancode_line_editor_unit.f =====
hw/rtl/sle_pkg.sv
hw/rtl/sle_ram.sv
hw/rtl/sle_ctrl.sv
hw/rtl/sle_dp.sv
hw/rtl/scancode_line_editor_unit.sv
sim/tb_scancode_line_editor_unit.sv
